@@ src/mc16_pkg.sv @@
// shared types and constants for the multicycle 16-bit core
package mc16_pkg;

    localparam int MemWords  = 256;
    localparam int MemAw     = $clog2(MemWords);

    // phase codes
    localparam logic [2:0] PH_FETCH0 = 3'd0;
    localparam logic [2:0] PH_FETCH1 = 3'd1;
    localparam logic [2:0] PH_DECODE = 3'd2;
    localparam logic [2:0] PH_OPER   = 3'd3;
    localparam logic [2:0] PH_EXEC   = 3'd4;
    localparam logic [2:0] PH_WBACK  = 3'd5;

    // opcodes
    localparam logic [3:0] OP_MOV = 4'd0;
    localparam logic [3:0] OP_ADD = 4'd1;
    localparam logic [3:0] OP_LDL = 4'd8;
    localparam logic [3:0] OP_LDH = 4'd9;
    localparam logic [3:0] OP_CMP = 4'd10;
    localparam logic [3:0] OP_JE  = 4'd11;
    localparam logic [3:0] OP_JMP = 4'd12;
    localparam logic [3:0] OP_LD  = 4'd13;
    localparam logic [3:0] OP_ST  = 4'd14;
    localparam logic [3:0] OP_HLT = 4'd15;

    localparam logic [2:0] PSW_REG = 3'd5;
    localparam logic [2:0] PC_REG  = 3'd7;

    // classified item handed from front to back
    typedef struct packed {
        logic        step;
        logic [7:0]  addr;
        logic [15:0] data;
    } t_item;

    // result beat
    typedef struct packed {
        logic [15:0] report_value;
        logic        illegal;
        logic        halted;
        logic        negative_flag;
        logic        zero_flag;
        logic [15:0] internal_bus;
        logic [15:0] program_counter;
        logic [2:0]  phase;
    } t_result;

endpackage

@@ src/mc16_front.sv @@
// input side: classifies beats and holds them in a two-entry queue
module mc16_front import mc16_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_user,
    input  logic [23:0] i_data,
    output logic        o_valid,
    input  logic        i_ready,
    output t_item       o_item
);
    t_item      r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       push, pop;
    t_item      item;

    // field split: mode from tuser, address and data from tdata
    assign item.step = i_user;
    assign item.addr = i_data[7:0];
    assign item.data = i_data[23:8];

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_item  = r_q[r_rp];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    // queue storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= item;
        end
    end

    // queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule

@@ src/mc16_back.sv @@
// execution side: memory, register file, phase sequencer and result register
module mc16_back import mc16_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  t_item       i_item,
    input  logic [7:0]  i_report_address,
    output logic        o_valid,
    input  logic        i_ready,
    output t_result     o_result
);
    logic [15:0] r_mem [MemWords];
    logic [15:0] r_rf [8];
    logic [2:0]  r_phase;
    logic [15:0] r_ir, r_mrl, r_opa, r_opb, r_res, r_rep_rd;
    logic [7:0]  r_ar;
    logic        r_halt, r_ill;
    logic        r_clr;
    logic [MemAw:0] r_ccnt;
    logic        r_ovalid;
    logic [38:0] r_out;

    logic [15:0] n_rf [8];
    logic [2:0]  n_phase;
    logic [15:0] n_ir, n_opa, n_opb, n_res;
    logic [7:0]  n_ar;
    logic        n_halt, n_ill;
    logic        mem_we;
    logic [MemAw-1:0] mem_wa;
    logic [15:0] mem_wd;
    logic        mem_re, rep_re;
    logic [3:0]  op;
    logic [15:0] dif, psw;
    logic        go;

    assign o_ready = !r_clr && (!r_ovalid || i_ready);
    assign go      = i_valid && o_ready;
    assign o_valid = r_ovalid;
    assign o_result = {(r_halt ? r_rep_rd : 16'd0), r_out};

    // memory reads: instruction or operand fetch, report word at halt
    assign mem_re = go && i_item.step && !r_halt &&
                    (r_phase == PH_FETCH1 || (r_phase == PH_OPER && r_ir[14:11] == OP_LD));
    assign rep_re = go && n_halt && !r_halt;

    // next-state of one beat
    always_comb begin
        for (int k = 0; k < 8; k++) n_rf[k] = r_rf[k];
        n_phase = r_phase; n_ir = r_ir; n_opa = r_opa;
        n_opb = r_opb; n_res = r_res; n_ar = r_ar; n_halt = r_halt;
        n_ill = r_ill;
        mem_we = 1'b0;
        mem_wa = i_item.addr[MemAw-1:0];
        mem_wd = i_item.data;
        op  = r_ir[14:11];
        dif = 16'd0;
        psw = r_rf[PSW_REG];
        if (r_clr) begin
            mem_we = 1'b1;
            mem_wa = r_ccnt[MemAw-1:0];
            mem_wd = 16'd0;
        end else if (!i_item.step) begin
            mem_we = 1'b1;
        end else if (!r_halt) begin
            unique case (r_phase)
                PH_FETCH1: begin
                    n_ar  = r_res[7:0];
                    n_res = r_opa + 16'd1;
                    n_phase = PH_DECODE;
                end
                PH_DECODE: begin
                    n_ir = r_mrl;
                    op = r_mrl[14:11];
                    n_rf[PC_REG] = r_res;
                    if (op >= 4'd2 && op <= 4'd7) begin
                        n_halt = 1'b1; n_ill = 1'b1;
                    end else begin
                        if (op == OP_MOV || op == OP_ADD || op == OP_CMP) begin
                            n_opa = n_rf[r_mrl[7:5]];
                            n_phase = PH_EXEC;
                        end else if (op == OP_LD || op == OP_ST) begin
                            n_opa = {8'd0, r_mrl[7:0]};
                            n_phase = PH_OPER;
                        end else begin
                            n_phase = PH_EXEC;
                        end
                        n_res = n_opa;
                    end
                end
                PH_OPER: begin
                    n_ar = r_res[7:0];
                    n_res = r_opa;
                    n_phase = PH_EXEC;
                end
                PH_EXEC: begin
                    if (op == OP_HLT) begin
                        n_halt = 1'b1; n_ill = 1'b0;
                    end else begin
                        if (op == OP_ADD || op == OP_CMP) begin
                            n_opb = r_res;
                            n_opa = r_rf[r_ir[10:8]];
                            if (op == OP_ADD) begin
                                n_res = n_opa + r_res;
                            end else begin
                                dif = n_opa - r_res;
                                psw[15] = dif[15];
                                psw[14] = (dif == 16'd0);
                                n_rf[PSW_REG] = psw;
                                n_res = dif;
                            end
                        end else begin
                            if (op == OP_LDL || op == OP_JE || op == OP_JMP)
                                n_opa = {8'd0, r_ir[7:0]};
                            else if (op == OP_LDH)
                                n_opa = {r_ir[7:0], 8'd0};
                            else if (op == OP_LD)
                                n_opa = r_mrl;
                            else if (op == OP_ST)
                                n_opa = r_rf[r_ir[10:8]];
                            n_res = n_opa;
                        end
                        n_phase = PH_WBACK;
                    end
                end
                PH_WBACK: begin
                    if (op == OP_ST) begin
                        mem_we = 1'b1;
                        mem_wa = r_ar[MemAw-1:0];
                        mem_wd = r_res;
                    end else if (op == OP_LDL || op == OP_LDH) begin
                        n_rf[r_ir[10:8]] = r_rf[r_ir[10:8]] | r_res;
                    end else if (op == OP_JE) begin
                        if (r_rf[PSW_REG][14]) n_rf[PC_REG] = r_res;
                    end else if (op == OP_JMP) begin
                        n_rf[PC_REG] = r_res;
                    end else if (op != OP_CMP) begin
                        n_rf[r_ir[10:8]] = r_res;
                    end
                    n_phase = PH_FETCH0;
                end
                default: begin
                    n_opa = r_rf[PC_REG];
                    n_res = n_opa;
                    n_phase = PH_FETCH1;
                end
            endcase
        end
    end

    // memory write port and registered read ports
    always_ff @(posedge i_clk) begin
        if (mem_we && (go || r_clr)) r_mem[mem_wa] <= mem_wd;
        if (mem_re) r_mrl <= r_mem[r_res[MemAw-1:0]];
        if (rep_re) r_rep_rd <= r_mem[i_report_address[MemAw-1:0]];
    end

    // architectural state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 8; k++) r_rf[k] <= 16'd0;
            r_phase <= PH_FETCH0; r_ir <= 16'd0; r_opa <= 16'd0;
            r_opb <= 16'd0; r_res <= 16'd0; r_ar <= 8'd0; r_halt <= 1'b0;
            r_ill <= 1'b0;
            r_clr <= 1'b1; r_ccnt <= '0; r_ovalid <= 1'b0;
        end else begin
            if (r_clr) begin
                r_ccnt <= r_ccnt + 1'b1;
                if (r_ccnt == (MemAw+1)'(MemWords - 1)) r_clr <= 1'b0;
            end
            if (go) begin
                for (int k = 0; k < 8; k++) r_rf[k] <= n_rf[k];
                r_phase <= n_phase; r_ir <= n_ir; r_opa <= n_opa;
                r_opb <= n_opb; r_res <= n_res; r_ar <= n_ar; r_halt <= n_halt;
                r_ill <= n_ill;
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // result register, report value comes from the halt read port
    always_ff @(posedge i_clk) begin
        if (go) begin
            r_out <= {n_ill, n_halt, n_rf[PSW_REG][15], n_rf[PSW_REG][14],
                      n_res, n_rf[PC_REG], n_phase};
        end
    end
endmodule

@@ src/multicycle_16bit_cpu_core.sv @@
// top level of the multicycle 16-bit core
// channel   | dir | beat contents
// s_axis    | in  | tuser: mode; tdata: address[7:0], data[15:0]
// m_axis    | out | tdata: phase, pc, bus, zero, neg, halted, illegal, report, zero fill
// cfg       | in  | report address, 8 bits
// one phase per step beat until halt, one beat per cycle back to back while neither side stalls
// an accepted input reaches the output through a queue entry, then the result register
// after reset a pass clears all 256 memory words; up to two input beats wait in the queue,
// cfg still taken
// a two-entry queue between front and back lets each side stall on its own
module multicycle_16bit_cpu_core import mc16_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic        s_axis_tuser,   // mode
    input  logic [23:0] s_axis_tdata,   // address[7:0], data[15:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata,   // phase[2:0], pc, bus, zero, neg, halted, illegal, report
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_data
);
    logic [7:0] r_report_address;
    logic       q_valid, q_ready;
    t_item      q_item;
    t_result    res;

    assign o_cfg_ready = 1'b1;

    // report address register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_report_address <= 8'd100;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_report_address <= i_cfg_data;
        end
    end

    mc16_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready),
        .i_user(s_axis_tuser), .i_data(s_axis_tdata),
        .o_valid(q_valid), .i_ready(q_ready), .o_item(q_item)
    );

    mc16_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(q_valid), .o_ready(q_ready), .i_item(q_item),
        .i_report_address(r_report_address),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready), .o_result(res)
    );

    assign m_axis_tdata = {1'b0, res};

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("result changed under stall");
    // illegal only with halted
    a_ill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && res.illegal |-> res.halted)
        else $error("illegal without halt");
    // phase in range
    a_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> res.phase <= PH_WBACK)
        else $error("phase out of range");
endmodule

@@ tb/testbench.sv @@
// self-checking testbench for the multicycle 16-bit core: program loads and phase steps
`timescale 1ns / 1ps

module testbench;
    import mc16_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    // expected-result tracker with its own copy of the core state
    class core_scoreboard;
        bit [15:0] regs [8];
        bit [15:0] mem [256];
        bit [2:0]  phase;
        bit [15:0] instr;
        bit [7:0]  addr_q;
        bit [15:0] data_q;
        bit [15:0] rd_latch;
        bit [15:0] bus_a;
        bit [15:0] bus_b;
        bit [15:0] res_bus;
        bit        halted;
        bit        illegal;
        bit [15:0] report;
        bit [7:0]  report_addr;
        t_result   pending [$];
        int        errors;

        function new();
            foreach (regs[i]) regs[i] = '0;
            foreach (mem[i]) mem[i] = '0;
            phase = PH_FETCH0;
            report_addr = 8'd100;
        endfunction

        function bit is_legal(bit [3:0] op);
            return op == OP_MOV || op == OP_ADD || op == OP_LDL || op == OP_LDH ||
                   op == OP_CMP || op == OP_JE || op == OP_JMP || op == OP_LD ||
                   op == OP_ST || op == OP_HLT;
        endfunction

        function void stop_core(bit bad);
            halted  = 1'b1;
            illegal = bad;
            report  = mem[report_addr];
        endfunction

        // one phase of the core
        function void run_phase();
            bit [3:0]  op;
            bit [2:0]  rd;
            bit [7:0]  imm;
            bit [15:0] diff;
            op  = instr[14:11];
            rd  = instr[10:8];
            imm = instr[7:0];
            case (phase)
                PH_FETCH1: begin
                    addr_q   = res_bus[7:0];
                    rd_latch = mem[addr_q];
                    res_bus  = bus_a + 16'd1;
                    phase    = PH_DECODE;
                end
                PH_DECODE: begin
                    instr = rd_latch;
                    op    = instr[14:11];
                    imm   = instr[7:0];
                    regs[PC_REG] = res_bus;
                    if (!is_legal(op)) begin
                        stop_core(1'b1);
                        return;
                    end
                    if (op == OP_MOV || op == OP_ADD || op == OP_CMP) begin
                        bus_a = regs[imm[7:5]];
                        phase = PH_EXEC;
                    end else if (op == OP_LD || op == OP_ST) begin
                        bus_a = {8'h00, imm};
                        phase = PH_OPER;
                    end else begin
                        phase = PH_EXEC;
                    end
                    res_bus = bus_a;
                end
                PH_OPER: begin
                    addr_q = res_bus[7:0];
                    if (op == OP_LD) rd_latch = mem[addr_q];
                    res_bus = bus_a;
                    phase   = PH_EXEC;
                end
                PH_EXEC: begin
                    if (op == OP_HLT) begin
                        stop_core(1'b0);
                        return;
                    end
                    if (op == OP_ADD || op == OP_CMP) begin
                        bus_b = res_bus;
                        bus_a = regs[rd];
                        if (op == OP_ADD) begin
                            res_bus = bus_a + bus_b;
                        end else begin
                            diff = bus_a - bus_b;
                            regs[PSW_REG][15] = diff[15];
                            regs[PSW_REG][14] = (diff == 16'd0);
                            res_bus = diff;
                        end
                    end else begin
                        if (op == OP_LDL || op == OP_JE || op == OP_JMP) begin
                            bus_a = {8'h00, imm};
                        end else if (op == OP_LDH) begin
                            bus_a = {imm, 8'h00};
                        end else if (op == OP_LD) begin
                            data_q = rd_latch;
                            bus_a  = data_q;
                        end else if (op == OP_ST) begin
                            bus_a = regs[rd];
                        end
                        res_bus = bus_a;
                    end
                    phase = PH_WBACK;
                end
                PH_WBACK: begin
                    if (op == OP_ST) begin
                        data_q = res_bus;
                        mem[addr_q] = data_q;
                    end else if (op == OP_LDL || op == OP_LDH) begin
                        regs[rd] = regs[rd] | res_bus;
                    end else if (op == OP_JE) begin
                        if (regs[PSW_REG][14]) regs[PC_REG] = res_bus;
                    end else if (op == OP_JMP) begin
                        regs[PC_REG] = res_bus;
                    end else if (op != OP_CMP) begin
                        regs[rd] = res_bus;
                    end
                    phase = PH_FETCH0;
                end
                default: begin
                    bus_a   = regs[PC_REG];
                    res_bus = bus_a;
                    phase   = PH_FETCH1;
                end
            endcase
        endfunction

        // accepted input beat: update state and queue the expected result
        function void note_input(bit step, bit [7:0] addr, bit [15:0] data);
            t_result r;
            if (!step) mem[addr] = data;
            else if (!halted) run_phase();
            r.phase           = phase;
            r.program_counter = regs[PC_REG];
            r.internal_bus    = res_bus;
            r.zero_flag       = regs[PSW_REG][14];
            r.negative_flag   = regs[PSW_REG][15];
            r.halted          = halted;
            r.illegal         = illegal;
            r.report_value    = report;
            pending.insert(pending.size(), r);
        endfunction

        function void cmp_field(string name, int exp_v, int got_v);
            if (exp_v != got_v) begin
                $display("%0t: %s expected %0h actual %0h", $time, name, exp_v, got_v);
                errors++;
            end
        endfunction

        // accepted result beat against the oldest expectation
        function void check_result(t_result got);
            t_result e;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result expected none actual %0h", $time, got);
                errors++;
                return;
            end
            e = pending.pop_front();
            cmp_field("phase", e.phase, got.phase);
            cmp_field("pc", e.program_counter, got.program_counter);
            cmp_field("bus", e.internal_bus, got.internal_bus);
            cmp_field("zero", e.zero_flag, got.zero_flag);
            cmp_field("neg", e.negative_flag, got.negative_flag);
            cmp_field("halted", e.halted, got.halted);
            cmp_field("illegal", e.illegal, got.illegal);
            cmp_field("report", e.report_value, got.report_value);
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic        s_axis_tuser = 1'b0;
    logic [23:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [55:0] m_axis_tdata;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [7:0]  i_cfg_data = '0;

    core_scoreboard sb = new();
    int  idle_mode = 0;   // 0 none, 1 sender, 2 receiver, 3 both
    int  cycles = 0;
    logic        out_hs = 1'b0;
    logic [55:0] out_beat = '0;

    multicycle_16bit_cpu_core dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tuser(s_axis_tuser), .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready), .i_cfg_data(i_cfg_data)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // receiver stall pattern
    always @(posedge i_clk) begin
        if (idle_mode == 2) m_axis_tready <= ($urandom_range(99) >= 84);
        else if (idle_mode == 3) m_axis_tready <= ($urandom_range(99) >= 14);
        else m_axis_tready <= 1'b1;
    end

    // sample the result side mid-cycle, check at the edge
    always @(negedge i_clk) begin
        out_hs   <= m_axis_tvalid && m_axis_tready;
        out_beat <= m_axis_tdata;
    end

    always @(posedge i_clk) begin
        if (out_hs) sb.check_result(t_result'(out_beat[54:0]));
    end

    // run limit
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // one input beat with optional leading gap
    task automatic send_beat(bit step, bit [7:0] addr, bit [15:0] data);
        int gap_pct;
        gap_pct = (idle_mode == 1) ? 84 : (idle_mode == 3) ? 14 : 0;
        while ($urandom_range(99) < gap_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= step;
        s_axis_tdata  <= {data, addr};
        forever begin
            @(negedge i_clk);
            if (s_axis_tready) break;
            @(posedge i_clk);
        end
        @(posedge i_clk);
        sb.note_input(step, addr, data);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // report address write while the core is quiet
    task automatic write_report_addr(bit [7:0] value);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        forever begin
            @(negedge i_clk);
            if (o_cfg_ready) break;
            @(posedge i_clk);
        end
        @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        sb.report_addr = value;
    endtask

    // random legal instruction that keeps the core running
    function automatic bit [15:0] rand_instr();
        bit [3:0] ops [9] = '{OP_MOV, OP_ADD, OP_LDL, OP_LDH, OP_CMP,
                              OP_JE, OP_JMP, OP_LD, OP_ST};
        return {1'($urandom), ops[$urandom_range(8)], 3'($urandom), 8'($urandom)};
    endfunction

    initial begin
        bit [7:0] reports [4];
        reports = '{8'd0, 8'd255, 8'($urandom), 8'h80};
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        write_report_addr(8'd255);

        // directed program touching every running opcode
        send_beat(1'b0, 8'd0,  {1'b0, OP_LDL, 3'd1, 8'hFF});
        send_beat(1'b0, 8'd1,  {1'b0, OP_LDH, 3'd1, 8'h80});
        send_beat(1'b0, 8'd2,  {1'b0, OP_LDL, 3'd2, 8'h01});
        send_beat(1'b0, 8'd3,  {1'b1, OP_ADD, 3'd1, 8'h40});
        send_beat(1'b0, 8'd4,  {1'b0, OP_CMP, 3'd1, 8'h20});
        send_beat(1'b0, 8'd5,  {1'b0, OP_JE,  3'd0, 8'h08});
        send_beat(1'b0, 8'd8,  {1'b0, OP_ST,  3'd1, 8'h80});
        send_beat(1'b0, 8'd9,  {1'b0, OP_LD,  3'd4, 8'h80});
        send_beat(1'b0, 8'd10, {1'b0, OP_CMP, 3'd2, 8'h20});
        send_beat(1'b0, 8'd11, {1'b0, OP_JE,  3'd0, 8'h00});
        send_beat(1'b0, 8'd12, {1'b0, OP_JMP, 3'd0, 8'h14});
        send_beat(1'b0, 8'd20, {1'b0, OP_MOV, 3'd6, 8'h80});
        send_beat(1'b0, 8'd255, 16'h87FF);
        send_beat(1'b1, 8'hFF, 16'hFFFF);

        // random traffic over the idle patterns, report address changed in between
        for (int p = 0; p < 4; p++) begin
            write_report_addr(reports[p]);
            idle_mode = p;
            for (int n = 0; n < 230; n++) begin
                if ($urandom_range(99) < 20)
                    send_beat(1'b0, 8'($urandom), rand_instr());
                else
                    send_beat(1'b1, 8'($urandom), 16'($urandom));
                // stretches with no idling inside each pattern
                if (n == 115) idle_mode = 0;
                if (n == 160) idle_mode = p;
            end
        end

        // halt instruction at the next fetch, then steps that must change nothing
        while (sb.phase != PH_FETCH0 && !sb.halted) send_beat(1'b1, 8'd0, 16'd0);
        send_beat(1'b0, sb.regs[PC_REG][7:0], {1'b0, OP_HLT, 11'd0});
        repeat (10) send_beat(1'b1, 8'd0, 16'd0);

        drain();
        repeat (20) @(posedge i_clk);
        if (sb.errors == 0) $display("SCOREBOARD CLEAN");
        else $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
